// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, c, r, a, b) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, c, r, a, b) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/cln_pkg.sv =====
`default_nettype none
package cln_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int SUM_W  = 38;
    localparam int ROOT_W = 19;
    localparam int NORM_W = 20;
    localparam int DEN_W  = 32;
    localparam int NUM_W  = 56;
    localparam int DIV_AW = 57;
    localparam int QBITS  = 17;
    localparam int STEP_W = 5;
    localparam logic [15:0] EPS_RESET = 16'd1;

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_ROOT_GO,
        ST_ROOT,
        ST_P1_READ,
        ST_P1_GO,
        ST_P1_WAIT,
        ST_P1_ACC,
        ST_P2_READ,
        ST_P2_LO,
        ST_P2_HI,
        ST_P2_NUM,
        ST_P2_GO,
        ST_P2_WAIT,
        ST_EMIT
    } cln_state_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] operand;
    } cln_sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } cln_sqrt_rsp_t;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [NUM_W-1:0] mag;
        logic [DEN_W-1:0] den;
    } cln_div_req_t;

    typedef struct packed {
        logic        done;
        logic        sat;
        logic [15:0] value;
    } cln_div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/cln_in_if.sv =====
`default_nettype none
interface cln_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [15:0] sample;
    logic signed [15:0] grad;
    logic               is_last_channel;

    modport source(output valid, command, sample, grad, is_last_channel, input ready);
    modport sink(input valid, command, sample, grad, is_last_channel, output ready);
endinterface
`default_nettype wire

// ===== rtl/cln_out_if.sv =====
`default_nettype none
interface cln_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] result_value;
    logic               result_last;
    logic               overflow;

    modport source(output valid, result_value, result_last, overflow, input ready);
    modport sink(input valid, result_value, result_last, overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/channel_l2_normalize_core.sv =====
// sequence: input items are taken while collecting; after the last item the bit-serial square
// root runs, then, unless the norm is zero, each channel gets a divide for y, and each result
// is read back (forward) or goes through a second divide (backward) on the shared 17-step divider
// throughput: one channel position at a time; no new item is taken until its last result
// reset: asynchronous active low, clears counters and state, epsilon returns to 1
`default_nettype none
`include "assert_macros.svh"
module channel_l2_normalize_core (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_write,
    input  logic  [15:0] cfg_data,
    cln_in_if.sink    in_ch,
    cln_out_if.source out_ch
);
    import cln_pkg::*;

    cln_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic                    dropped_reg, dropped_next;
    logic                    bwd_reg, bwd_next;
    logic [15:0]             eps_reg;
    logic [NORM_W-1:0]       norm_reg, norm_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic signed [SUM_W-1:0] s_reg, s_next;
    logic signed [31:0]      prod_reg, prod_next;
    logic signed [15:0]      dy_reg, dy_next;
    logic signed [15:0]      y_reg, y_next;
    logic                    sat_reg, sat_next;
    logic signed [35:0]      pp_lo_reg, pp_lo_next;
    logic signed [34:0]      pp_hi_reg, pp_hi_next;
    logic signed [NUM_W-1:0] num_reg, num_next;
    logic [15:0]             res_reg, res_next;
    logic                    of_reg, of_next;

    logic                    in_acc;
    logic                    out_acc;
    logic                    store_ok;
    logic [IDX_W-1:0]        last_idx;
    logic                    at_last;
    logic signed [31:0]      sq;
    logic [NORM_W-1:0]       norm_calc;
    logic signed [15:0]      rd_x;
    logic signed [15:0]      rd_dy;
    logic signed [15:0]      rd_y;
    logic [15:0]             abs_x;
    logic [NUM_W-1:0]        abs_num;
    logic signed [NUM_W-1:0] ys;

    logic                    a_we;
    logic [31:0]             a_rdata;
    logic                    y_we;
    logic [16:0]             y_rdata;

    cln_sqrt_req_t sqrt_req;
    cln_sqrt_rsp_t sqrt_rsp;
    cln_div_req_t  div_req;
    cln_div_rsp_t  div_rsp;

    cln_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_xdy_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata ({in_ch.sample, in_ch.grad}),
        .raddr (idx_reg),
        .rdata (a_rdata)
    );

    cln_ram #(.WIDTH(17), .DEPTH(MAX_CHANNELS)) u_y_ram (
        .clk   (clk),
        .we    (y_we),
        .waddr (idx_reg),
        .wdata ({div_rsp.sat, div_rsp.value}),
        .raddr (idx_reg),
        .rdata (y_rdata)
    );

    cln_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    cln_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign out_acc  = out_ch.valid && out_ch.ready;
    assign store_ok = cnt_reg < CNT_W'(MAX_CHANNELS);
    assign last_idx = IDX_W'(cnt_reg - CNT_W'(1));
    assign at_last  = idx_reg == last_idx;
    assign rd_x     = a_rdata[31:16];
    assign rd_dy    = a_rdata[15:0];
    assign rd_y     = y_rdata[15:0];
    assign norm_calc = NORM_W'(sqrt_rsp.root) + NORM_W'(eps_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (in_acc && in_ch.is_last_channel)
                begin
                    state_next = ST_ROOT_GO;
                end
            end
            ST_ROOT_GO: state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (sqrt_rsp.done)
                begin
                    state_next = (norm_calc == '0) ? ST_P2_READ : ST_P1_READ;
                end
            end
            ST_P1_READ: state_next = ST_P1_GO;
            ST_P1_GO:   state_next = ST_P1_WAIT;
            ST_P1_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_P1_ACC;
                end
            end
            ST_P1_ACC:  state_next = at_last ? ST_P2_READ : ST_P1_READ;
            ST_P2_READ: state_next = ST_P2_LO;
            ST_P2_LO:
            begin
                if (norm_reg == '0 || !bwd_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_P2_HI;
                end
            end
            ST_P2_HI:  state_next = ST_P2_NUM;
            ST_P2_NUM: state_next = ST_P2_GO;
            ST_P2_GO:  state_next = ST_P2_WAIT;
            ST_P2_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    state_next = at_last ? ST_COLLECT : ST_P2_READ;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    // handshakes, memory writes and unit requests
    always_comb
    begin
        in_ch.ready      = state_reg == ST_COLLECT;
        out_ch.valid     = state_reg == ST_EMIT;
        a_we             = in_acc && store_ok;
        y_we             = state_reg == ST_P1_WAIT && div_rsp.done;
        sqrt_req.start   = state_reg == ST_ROOT_GO;
        sqrt_req.operand = sum_reg;
        abs_x            = rd_x[15] ? 16'd0 - rd_x : rd_x;
        abs_num          = num_reg[NUM_W-1] ? NUM_W'(0) - num_reg : num_reg;
        div_req.start    = state_reg == ST_P1_GO || state_reg == ST_P2_GO;
        if (state_reg == ST_P1_GO)
        begin
            div_req.neg = rd_x[15];
            div_req.mag = NUM_W'(abs_x) << 12;
            div_req.den = DEN_W'(norm_reg);
        end
        else
        begin
            div_req.neg = num_reg[NUM_W-1];
            div_req.mag = abs_num;
            div_req.den = DEN_W'(norm_reg) << 12;
        end
    end

    assign out_ch.result_value = res_reg;
    assign out_ch.result_last  = at_last;
    assign out_ch.overflow     = of_reg || dropped_reg;

    // datapath
    always_comb
    begin
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        dropped_next = dropped_reg;
        bwd_next     = bwd_reg;
        norm_next    = norm_reg;
        idx_next     = idx_reg;
        s_next       = s_reg;
        prod_next    = prod_reg;
        dy_next      = dy_reg;
        y_next       = y_reg;
        sat_next     = sat_reg;
        pp_lo_next   = pp_lo_reg;
        pp_hi_next   = pp_hi_reg;
        num_next     = num_reg;
        res_next     = res_reg;
        of_next      = of_reg;
        sq           = in_ch.sample * in_ch.sample;
        ys           = (NUM_W'(pp_hi_reg) <<< 19) + NUM_W'(pp_lo_reg);
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_acc)
                begin
                    if (store_ok)
                    begin
                        sum_next = sum_reg + SUM_W'($unsigned(sq));
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    bwd_next = in_ch.command;
                end
            end
            ST_ROOT:
            begin
                norm_next = norm_calc;
                idx_next  = '0;
                s_next    = '0;
            end
            ST_P1_GO: dy_next = rd_dy;
            ST_P1_WAIT: prod_next = $signed(div_rsp.value) * dy_reg;
            ST_P1_ACC:
            begin
                s_next   = s_reg + SUM_W'(prod_reg);
                idx_next = at_last ? '0 : idx_reg + IDX_W'(1);
            end
            ST_P2_LO:
            begin
                dy_next    = rd_dy;
                y_next     = rd_y;
                sat_next   = y_rdata[16];
                pp_lo_next = rd_y * $signed({1'b0, s_reg[ROOT_W-1:0]});
                if (norm_reg == '0)
                begin
                    res_next = '0;
                    of_next  = 1'b1;
                end
                else
                begin
                    res_next = rd_y;
                    of_next  = y_rdata[16];
                end
            end
            ST_P2_HI: pp_hi_next = y_reg * $signed(s_reg[SUM_W-1:ROOT_W]);
            ST_P2_NUM: num_next = (NUM_W'(dy_reg) <<< 24) - ys;
            ST_P2_WAIT:
            begin
                res_next = div_rsp.value;
                of_next  = sat_reg || div_rsp.sat;
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    if (at_last)
                    begin
                        cnt_next     = '0;
                        sum_next     = '0;
                        dropped_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            dropped_reg <= 1'b0;
            eps_reg     <= EPS_RESET;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            dropped_reg <= dropped_next;
            idx_reg     <= idx_next;
            if (cfg_write)
            begin
                eps_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bwd_reg   <= bwd_next;
        norm_reg  <= norm_next;
        s_reg     <= s_next;
        prod_reg  <= prod_next;
        dy_reg    <= dy_next;
        y_reg     <= y_next;
        sat_reg   <= sat_next;
        pp_lo_reg <= pp_lo_next;
        pp_hi_reg <= pp_hi_next;
        num_reg   <= num_next;
        res_reg   <= res_next;
        of_reg    <= of_next;
    end

    `ASSERT_IMPLY(a_no_overlap, clk, rst_n, out_ch.valid, !in_ch.ready)
    `ASSERT_NEXT(a_position_clears, clk, rst_n, out_acc && out_ch.result_last,
        cnt_reg == '0 && !dropped_reg)
    `ASSERT_NEXT(a_drop_flagged, clk, rst_n, in_acc && !store_ok, dropped_reg)
endmodule
`default_nettype wire

// ===== rtl/cln_ram.sv =====
`default_nettype none
module cln_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== rtl/cln_sqrt.sv =====
`default_nettype none
module cln_sqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cln_pkg::cln_sqrt_req_t req,
    output cln_pkg::cln_sqrt_rsp_t rsp
);
    import cln_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SUM_W-1:0] v_reg, v_next;
    logic [SUM_W-1:0] res_reg, res_next;
    logic [SUM_W-1:0] bit_reg, bit_next;
    logic [SUM_W-1:0] trial;

    // one result bit per cycle, bit walks down by powers of four
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        trial     = res_reg + bit_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            v_next    = req.operand;
            res_next  = '0;
            bit_next  = SUM_W'(1) << (SUM_W - 2);
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == SUM_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[ROOT_W-1:0];
endmodule
`default_nettype wire

// ===== rtl/cln_div.sv =====
`default_nettype none
module cln_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cln_pkg::cln_div_req_t req,
    output cln_pkg::cln_div_rsp_t rsp
);
    import cln_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              neg_reg, neg_next;
    logic              big_reg, big_next;
    logic [DIV_AW-1:0] rem_reg, rem_next;
    logic [DIV_AW-1:0] dsh_reg, dsh_next;
    logic [QBITS-1:0]  q_reg, q_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIV_AW-1:0] biased;
    logic [DIV_AW-1:0] limit;
    logic              pos_sat;
    logic              neg_sat;
    logic              sat;
    logic [15:0]       neg_val;

    // round half away: (mag + den/2) / den, one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        big_next  = big_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        step_next = step_reg;
        biased    = DIV_AW'(req.mag) + DIV_AW'(req.den >> 1);
        limit     = DIV_AW'(req.den) << QBITS;
        if (req.start)
        begin
            neg_next  = req.neg;
            q_next    = '0;
            rem_next  = biased;
            dsh_next  = DIV_AW'(req.den) << (QBITS - 1);
            step_next = STEP_W'(QBITS - 1);
            // quotient cannot fit, saturate without iterating
            if (biased >= limit)
            begin
                big_next  = 1'b1;
                done_next = 1'b1;
            end
            else
            begin
                big_next  = 1'b0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[QBITS-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[QBITS-2:0], 1'b0};
            end
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        big_reg  <= big_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        step_reg <= step_next;
    end

    always_comb
    begin
        pos_sat = q_reg > QBITS'(32767);
        neg_sat = q_reg > QBITS'(32768);
        sat     = big_reg || (neg_reg ? neg_sat : pos_sat);
        neg_val = 16'd0 - q_reg[15:0];
        rsp.done = done_reg;
        rsp.sat  = sat;
        if (sat)
        begin
            rsp.value = neg_reg ? 16'h8000 : 16'h7fff;
        end
        else
        begin
            rsp.value = neg_reg ? neg_val : q_reg[15:0];
        end
    end
endmodule
`default_nettype wire
